FILE: design/brf_pkg.sv
`timescale 1ns / 1ps
package brf_pkg;

	localparam int SLOTS_DEF = 1024;
	localparam int LANES     = 8;

	localparam int OP_W   = 2;
	localparam int DATA_W = 64;
	localparam int CNT_W  = 4;
	localparam int USED_W = 10;
	localparam int LANE_W = 3;

	localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
	localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK = 2'd2;
	localparam logic [OP_W-1:0] OP_BAD  = 2'd3;

	typedef struct packed {
		logic latch;
		logic eval;
		logic wr;
		logic rd;
		logic cap;
		logic fin;
	} brf_cmd_t;

	typedef struct packed {
		logic enq;
		logic lanes_done;
	} brf_sts_t;

endpackage

FILE: design/byte_ring_fifo_top.sv
`timescale 1ns / 1ps
// Byte ring FIFO: enqueue, dequeue or peek of up to 8 bytes per request.
// Request channel: opcode, write_bytes, request_count and allow_partial are
// taken at a rising edge where start is high and busy is low.
// Result channel: success, moved_count, read_bytes and used_count are valid
// for exactly one cycle while done is high; the receiver cannot stall.
// Steps after the start edge: EVAL checks the request, MOVE steps move
// n bytes (n = bytes actually moved, 0 on failure), then FIN registers
// the result. busy drops as done rises, so a new request may be issued in
// the done cycle. The byte store is single-port: an enqueue writes one
// byte a cycle in MOVE, a dequeue or peek reads each byte in MOVE (address)
// then CAP (registered data).
// Reset (arst_n low) empties the FIFO: both pointers return to zero, the
// store keeps stale contents that are never read back.
// Capacity is SLOTS-1 bytes; one slot always stays empty.
module byte_ring_fifo_top #(
	parameter int SLOTS = brf_pkg::SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [brf_pkg::OP_W-1:0]     opcode,
	input  logic [brf_pkg::DATA_W-1:0]   write_bytes,
	input  logic [brf_pkg::CNT_W-1:0]    request_count,
	input  logic                         allow_partial,
	output logic                         done,
	output logic                         success,
	output logic [brf_pkg::CNT_W-1:0]    moved_count,
	output logic [brf_pkg::DATA_W-1:0]   read_bytes,
	output logic [brf_pkg::USED_W-1:0]   used_count
);
	import brf_pkg::*;

	brf_cmd_t cmd;
	brf_sts_t sts;

	brf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	brf_dpath #(
		.SLOTS (SLOTS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (opcode),
		.write_bytes   (write_bytes),
		.request_count (request_count),
		.allow_partial (allow_partial),
		.success       (success),
		.moved_count   (moved_count),
		.read_bytes    (read_bytes),
		.used_count    (used_count)
	);

endmodule

FILE: design/brf_ctrl.sv
`timescale 1ns / 1ps
module brf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	input  brf_pkg::brf_sts_t sts,
	output brf_pkg::brf_cmd_t cmd
);
	import brf_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_MOVE = 3'd2;
	localparam logic [2:0] S_CAP  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0] state_q, state_d;
	logic       done_q;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.latch = start && (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_MOVE;
			end
			S_MOVE: begin
				if (sts.lanes_done) begin
					state_d = S_FIN;
				end else if (sts.enq) begin
					cmd.wr = 1'b1;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_CAP;
				end
			end
			S_CAP: begin
				cmd.cap = 1'b1;
				state_d = S_MOVE;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.fin;
		end
	end

	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_FIN)
		else $error("result strobe without finish step");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |=> busy)
		else $error("request taken but block not busy");

endmodule

FILE: design/brf_dpath.sv
`timescale 1ns / 1ps
module brf_dpath #(
	parameter int SLOTS = brf_pkg::SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  brf_pkg::brf_cmd_t            cmd,
	output brf_pkg::brf_sts_t            sts,
	input  logic [brf_pkg::OP_W-1:0]     opcode,
	input  logic [brf_pkg::DATA_W-1:0]   write_bytes,
	input  logic [brf_pkg::CNT_W-1:0]    request_count,
	input  logic                         allow_partial,
	output logic                         success,
	output logic [brf_pkg::CNT_W-1:0]    moved_count,
	output logic [brf_pkg::DATA_W-1:0]   read_bytes,
	output logic [brf_pkg::USED_W-1:0]   used_count
);
	import brf_pkg::*;

	localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int FW = PW + 1;
	localparam int AW = (FW > CNT_W) ? FW : CNT_W;
	localparam int UW = (FW > USED_W) ? FW : USED_W;
	localparam logic [PW-1:0] PTR_LAST = PW'(SLOTS - 1);

	logic [7:0]        mem [SLOTS];
	logic [7:0]        rd_data_q;

	logic [PW-1:0]     rp_q, wp_q, p_q;
	logic [OP_W-1:0]   op_q;
	logic [DATA_W-1:0] wdata_q, rdata_q;
	logic [CNT_W-1:0]  req_q, cnt_q, lane_q;
	logic              part_q, ok_q;

	logic              success_q;
	logic [CNT_W-1:0]  moved_q;
	logic [DATA_W-1:0] rbytes_q;
	logic [USED_W-1:0] used_q;

	logic [FW-1:0]     used_now, used_fin;
	logic [AW-1:0]     avail, req_ext;
	logic              ok_d;
	logic [CNT_W-1:0]  cnt_d;
	logic [PW-1:0]     p_inc, rp_fin, wp_fin;
	logic [UW-1:0]     used_ext;

	assign used_now = (wp_q >= rp_q) ? FW'(wp_q) - FW'(rp_q)
	                                 : FW'(wp_q) + FW'(SLOTS) - FW'(rp_q);

	always_comb begin
		case (op_q)
			OP_ENQ:  avail = AW'(FW'(SLOTS - 1) - used_now);
			default: avail = AW'(used_now);
		endcase
		req_ext = AW'(req_q);
		ok_d    = 1'b1;
		cnt_d   = req_q;
		if (op_q == OP_BAD || req_q > CNT_W'(LANES)) begin
			ok_d  = 1'b0;
			cnt_d = '0;
		end else if (req_ext > avail) begin
			if (part_q) begin
				cnt_d = avail[CNT_W-1:0];
			end else begin
				ok_d  = 1'b0;
				cnt_d = '0;
			end
		end
	end

	assign p_inc  = (p_q == PTR_LAST) ? '0 : p_q + 1'b1;
	assign rp_fin = (op_q == OP_DEQ) ? p_q : rp_q;
	assign wp_fin = (op_q == OP_ENQ) ? p_q : wp_q;
	assign used_fin = (wp_fin >= rp_fin) ? FW'(wp_fin) - FW'(rp_fin)
	                                     : FW'(wp_fin) + FW'(SLOTS) - FW'(rp_fin);
	assign used_ext = UW'(used_fin);

	assign sts.enq        = (op_q == OP_ENQ);
	assign sts.lanes_done = (lane_q == cnt_q);

	always_ff @(posedge clk) begin
		if (cmd.wr) mem[p_q] <= wdata_q[lane_q[LANE_W-1:0]*8 +: 8];
		if (cmd.rd) rd_data_q <= mem[p_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0;
			wp_q <= '0;
		end else if (cmd.fin && ok_q) begin
			rp_q <= rp_fin;
			wp_q <= wp_fin;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= opcode;
			wdata_q <= write_bytes;
			req_q   <= request_count;
			part_q  <= allow_partial;
			rdata_q <= '0;
			lane_q  <= '0;
		end
		if (cmd.eval) begin
			ok_q  <= ok_d;
			cnt_q <= cnt_d;
			p_q   <= (op_q == OP_ENQ) ? wp_q : rp_q;
		end
		if (cmd.wr) begin
			p_q    <= p_inc;
			lane_q <= lane_q + 1'b1;
		end
		if (cmd.cap) begin
			rdata_q[lane_q[LANE_W-1:0]*8 +: 8] <= rd_data_q;
			p_q    <= p_inc;
			lane_q <= lane_q + 1'b1;
		end
		if (cmd.fin) begin
			success_q <= ok_q;
			moved_q   <= cnt_q;
			rbytes_q  <= rdata_q;
			used_q    <= used_ext[USED_W-1:0];
		end
	end

	assign success     = success_q;
	assign moved_count = moved_q;
	assign read_bytes  = rbytes_q;
	assign used_count  = used_q;

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> success_q || (moved_q == '0 && rbytes_q == '0))
		else $error("failed request moved bytes");
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rp_q <= PTR_LAST) && (wp_q <= PTR_LAST))
		else $error("pointer beyond store");
	a_lane_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr || cmd.cap) |-> (lane_q < cnt_q) && (cnt_q <= CNT_W'(LANES)))
		else $error("lane step beyond count");

endmodule

FILE: bench/byte_ring_fifo_top_tb.sv
`timescale 1ns / 1ps
module byte_ring_fifo_top_tb;
	import brf_pkg::*;

	localparam int SLOTS      = SLOTS_DEF;
	localparam int ITEMS      = 1150;
	localparam int CALM_ITEMS = 150;

	typedef struct packed {
		logic              success;
		logic [CNT_W-1:0]  moved;
		logic [DATA_W-1:0] rdata;
		logic [USED_W-1:0] used;
	} fifo_result_t;

	class ring_model;
		logic [7:0]   store [0:SLOTS-1];
		int           rd_ptr;
		int           wr_ptr;
		int           mismatches;
		fifo_result_t pending_results [$];

		function new();
			rd_ptr = 0;
			wr_ptr = 0;
			mismatches = 0;
		endfunction

		function int fill();
			return (wr_ptr + SLOTS - rd_ptr) % SLOTS;
		endfunction

		function void note_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] data,
				logic [CNT_W-1:0] cnt, logic partial);
			fifo_result_t r;
			int used;
			int room;
			int n;
			int p;
			logic ok;
			r = '0;
			used = fill();
			n = cnt;
			ok = 1'b1;
			if (op == OP_BAD || n > LANES) begin
				ok = 1'b0;
			end else begin
				room = (op == OP_ENQ) ? SLOTS - 1 - used : used;
				if (n > room) begin
					if (partial) begin
						n = room;
					end else begin
						ok = 1'b0;
					end
				end
			end
			if (!ok) begin
				r.used = USED_W'(used);
			end else begin
				if (op == OP_ENQ) begin
					for (int i = 0; i < n; i++) begin
						store[wr_ptr] = data[8*i +: 8];
						wr_ptr = (wr_ptr + 1) % SLOTS;
					end
				end else begin
					p = rd_ptr;
					for (int i = 0; i < n; i++) begin
						r.rdata[8*i +: 8] = store[p];
						p = (p + 1) % SLOTS;
					end
					if (op == OP_DEQ) begin
						rd_ptr = p;
					end
				end
				r.success = 1'b1;
				r.moved = CNT_W'(n);
				r.used = USED_W'(fill());
			end
			pending_results.push_back(r);
		endfunction

		function void check_result(logic success, logic [CNT_W-1:0] moved,
				logic [DATA_W-1:0] rdata, logic [USED_W-1:0] used);
			fifo_result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result with no request outstanding: ok=%0b n=%0d d=%h u=%0d",
						$realtime, success, moved, rdata, used);
				end
				return;
			end
			want = pending_results.pop_front();
			if (success !== want.success || moved !== want.moved ||
					rdata !== want.rdata || used !== want.used) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: mismatch exp ok=%0b n=%0d d=%h u=%0d got ok=%0b n=%0d d=%h u=%0d",
						$realtime, want.success, want.moved, want.rdata, want.used,
						success, moved, rdata, used);
				end
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [OP_W-1:0]   opcode = OP_ENQ;
	logic [DATA_W-1:0] write_bytes = '0;
	logic [CNT_W-1:0]  request_count = '0;
	logic              allow_partial = 1'b0;
	logic              busy;
	logic              done;
	logic              success;
	logic [CNT_W-1:0]  moved_count;
	logic [DATA_W-1:0] read_bytes;
	logic [USED_W-1:0] used_count;

	ring_model model;

	byte_ring_fifo_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.write_bytes(write_bytes),
		.request_count(request_count),
		.allow_partial(allow_partial),
		.done(done),
		.success(success),
		.moved_count(moved_count),
		.read_bytes(read_bytes),
		.used_count(used_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk) begin
		if (done === 1'b1) begin
			model.check_result(success, moved_count, read_bytes, used_count);
		end
	end

	task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data,
			input logic [CNT_W-1:0] cnt, input logic partial);
		start <= 1'b1;
		opcode <= op;
		write_bytes <= data;
		request_count <= cnt;
		allow_partial <= partial;
		do @(posedge clk); while (busy !== 1'b0);
		model.note_request(op, data, cnt, partial);
	endtask

	task automatic idle(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic hold_until_drained();
		start <= 1'b0;
		@(posedge clk);
		while (model.pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic random_request(input bit filling);
		int roll;
		logic [OP_W-1:0] op;
		logic [CNT_W-1:0] cnt;
		roll = $urandom_range(0, 99);
		if (roll >= 94) begin
			op = OP_W'($urandom_range(0, 3));
		end else if (filling) begin
			op = (roll < 70) ? OP_ENQ : (roll < 82) ? OP_DEQ : OP_PEEK;
		end else begin
			op = (roll < 70) ? OP_DEQ : (roll < 80) ? OP_PEEK : OP_ENQ;
		end
		roll = $urandom_range(0, 99);
		if (roll < 50) begin
			cnt = CNT_W'(LANES);
		end else if (roll < 92) begin
			cnt = CNT_W'($urandom_range(0, LANES));
		end else begin
			cnt = CNT_W'($urandom_range(LANES + 1, 15));
		end
		send_request(op, {$urandom, $urandom}, cnt, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		bit filling;
		int edge_hits;
		int guard;
		model = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty FIFO, zero counts, oversize counts, bad opcode, partial shrink
		send_request(OP_DEQ,  64'h0, 4'd8, 1'b0);
		send_request(OP_PEEK, 64'h0, 4'd1, 1'b1);
		send_request(OP_ENQ,  64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0);
		send_request(OP_ENQ,  64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
		send_request(OP_ENQ,  64'hA5A5_A5A5_A5C3_3C5A, 4'd3, 1'b0);
		send_request(OP_PEEK, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
		send_request(OP_DEQ,  64'h0, 4'd9, 1'b1);
		send_request(OP_ENQ,  64'h1234_5678_9ABC_DEF0, 4'd15, 1'b1);
		send_request(OP_BAD,  64'h1234_5678_9ABC_DEF0, 4'd4, 1'b1);
		send_request(OP_PEEK, 64'h0, 4'd15, 1'b0);
		send_request(OP_DEQ,  64'h0, 4'd8, 1'b1);
		send_request(OP_DEQ,  64'h0, 4'd5, 1'b0);
		send_request(OP_DEQ,  64'h0, 4'd5, 1'b1);
		send_request(OP_ENQ,  64'h0, 4'd8, 1'b0);
		send_request(OP_ENQ,  64'h0123_4567_89AB_CDEF, 4'd8, 1'b1);
		send_request(OP_PEEK, 64'h0, 4'd0, 1'b0);
		send_request(OP_DEQ,  64'h0, 4'd0, 1'b1);
		send_request(OP_BAD,  64'h0, 4'd0, 1'b0);
		send_request(OP_DEQ,  64'h0, 4'd8, 1'b0);
		send_request(OP_PEEK, 64'h0, 4'd8, 1'b0);
		send_request(OP_DEQ,  64'h0, 4'd8, 1'b1);
		send_request(OP_DEQ,  64'h0, 4'd1, 1'b1);
		hold_until_drained();

		// alternate fill and drain phases so full, empty and pointer wrap all occur
		filling = 1'b1;
		edge_hits = 0;
		for (int i = 0; i < ITEMS; i++) begin
			if (filling && model.fill() == SLOTS - 1) begin
				edge_hits++;
			end else if (!filling && model.fill() == 0) begin
				edge_hits++;
			end
			if (edge_hits > 8) begin
				filling = !filling;
				edge_hits = 0;
			end
			random_request(filling);
			if (i == 400 || i == 800) begin
				hold_until_drained();
			end else if (i < ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0) begin
				idle($urandom_range(1, 16));
			end
		end

		start <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (model.pending_results.size() != 0 && guard < 500) begin
			@(posedge clk);
			guard++;
		end
		repeat (30) @(posedge clk);
		if (model.mismatches == 0 && model.pending_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
